@@ rtl/qrm_pkg.sv @@
`timescale 1ns / 1ps

package qrm_pkg;

  // Default widths of the quaternion components and of the matrix fraction.
  localparam int INPUT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 30;

  // Every matrix entry leaves the block as a 32-bit two's complement word.
  localparam int ENTRY_WIDTH = 32;

  // Number of matrix entries, row-major from m00 to m22.
  localparam int NUM_ENTRIES = 9;

  // Output frame register codes.
  localparam logic FRAME_DRONE_TO_WORLD = 1'b0;
  localparam logic FRAME_GRID_TO_CAMERA = 1'b1;

endpackage

@@ rtl/quaternion_to_rotation_matrix.sv @@
`timescale 1ns / 1ps

// Turns a quaternion of signed integers at any common scale into its 3x3 rotation matrix in
// signed Q1.FRACTION_BITS. Each entry is the exact ratio of a quadratic form over the squared
// norm, rounded to nearest with ties away from zero and held within +/-1. A zero quaternion
// gives out_tuser low and an all-zero matrix. cfg_wr_data selects the drone-to-world matrix (0)
// or the grid-to-camera matrix through the fixed downward mount (1); write it only while the
// block is idle. One beat is accepted every cycle unless every stage holds a beat and the
// output is held; the restoring divider produces one quotient bit per pipeline stage for all
// nine entries in parallel. Stalls ripple back stage by stage, so bubbles inside the pipeline
// are squeezed out while the output waits.
module quaternion_to_rotation_matrix #(
  parameter int INPUT_WIDTH   = qrm_pkg::INPUT_WIDTH_DEF,
  parameter int FRACTION_BITS = qrm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_wr_en,
  input  logic                                      cfg_wr_data,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // Fields from bit 0 up: q_x, q_y, q_z, q_w, then zero padding to whole bytes.
  input  logic [((4*INPUT_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // Fields from bit 0 up: m00, m01, m02, m10, m11, m12, m20, m21, m22.
  output logic [qrm_pkg::NUM_ENTRIES*qrm_pkg::ENTRY_WIDTH-1:0] out_tdata,
  // Fields from bit 0 up: valid_res.
  output logic                                      out_tuser
);

  localparam int W   = INPUT_WIDTH;
  localparam int PW  = 2 * W;          // product width
  localparam int NW  = 2 * W + 2;      // signed numerator width
  localparam int DW  = 2 * W + 1;      // magnitude and denominator width
  localparam int QW  = FRACTION_BITS + 2;
  localparam int ND  = QW;             // one divider stage per quotient bit
  localparam int NS  = ND + 5;         // all pipeline stages, output register last
  localparam int NE  = qrm_pkg::NUM_ENTRIES;
  localparam int EW  = qrm_pkg::ENTRY_WIDTH;
  localparam int OUT_STAGE = NS - 1;

  // Configuration register.
  logic frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= qrm_pkg::FRAME_DRONE_TO_WORLD;
    end else if (cfg_wr_en) begin
      frame_r <= cfg_wr_data;
    end
  end

  // Stage valid bits and the backward ready chain.
  logic [NS-1:0] v_r;
  logic [NS:0]   ready;
  logic [NS-1:0] v_src;

  always_comb begin
    ready[NS] = out_tready;
    for (int s = NS - 1; s >= 0; s--) begin
      ready[s] = !v_r[s] || ready[s+1];
    end
    v_src = {v_r[NS-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (ready[s]) begin
          v_r[s] <= v_src[s];
        end
      end
    end
  end

  assign in_tready  = ready[0];
  assign out_tvalid = v_r[OUT_STAGE];

  // Stage 0: capture the components.
  logic signed [W-1:0] x_r, y_r, z_r, w_r;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      x_r <= in_tdata[W-1:0];
      y_r <= in_tdata[2*W-1:W];
      z_r <= in_tdata[3*W-1:2*W];
      w_r <= in_tdata[4*W-1:3*W];
    end
  end

  // Stage 1: the ten products xx, yy, zz, ww, xy, xz, yz, wx, wy, wz.
  logic signed [PW-1:0] p_r [0:9];

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      p_r[0] <= x_r * x_r;
      p_r[1] <= y_r * y_r;
      p_r[2] <= z_r * z_r;
      p_r[3] <= w_r * w_r;
      p_r[4] <= x_r * y_r;
      p_r[5] <= x_r * z_r;
      p_r[6] <= y_r * z_r;
      p_r[7] <= w_r * x_r;
      p_r[8] <= w_r * y_r;
      p_r[9] <= w_r * z_r;
    end
  end

  // Stage 2: squared norm, the pair sums for the diagonal and the signed off-diagonal sums.
  logic signed [NW-1:0] pe [0:9];
  logic signed [NW-1:0] den2_r;
  logic signed [NW-1:0] s2_r [0:NE-1];

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      pe[k] = NW'(p_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      den2_r   <= (pe[0] + pe[1]) + (pe[2] + pe[3]);
      s2_r[0]  <= pe[1] + pe[2];
      s2_r[1]  <= pe[4] - pe[9];
      s2_r[2]  <= pe[5] + pe[8];
      s2_r[3]  <= pe[4] + pe[9];
      s2_r[4]  <= pe[0] + pe[2];
      s2_r[5]  <= pe[6] - pe[7];
      s2_r[6]  <= pe[5] - pe[8];
      s2_r[7]  <= pe[6] + pe[7];
      s2_r[8]  <= pe[0] + pe[1];
    end
  end

  // Stage 3: numerators split into sign and magnitude; the magnitude never exceeds the norm.
  logic signed [NW-1:0] num3 [0:NE-1];
  logic [NW-1:0]        abs3 [0:NE-1];
  logic [DW-1:0]        den3_r;
  logic                 zero3_r;
  logic [NE-1:0]        neg3_r;
  logic [DW-1:0]        mag3_r [0:NE-1];

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      if (e == 0 || e == 4 || e == 8) begin
        num3[e] = den2_r - (s2_r[e] <<< 1);
      end else begin
        num3[e] = s2_r[e] <<< 1;
      end
      abs3[e] = num3[e][NW-1] ? NW'(-num3[e]) : NW'(num3[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      den3_r  <= den2_r[DW-1:0];
      zero3_r <= (den2_r == '0);
      for (int e = 0; e < NE; e++) begin
        neg3_r[e] <= num3[e][NW-1];
        mag3_r[e] <= abs3[e][DW-1:0];
      end
    end
  end

  // Divider stages: one restoring step per stage for all nine entries.
  logic [DW-1:0] rem_r  [0:ND-1][0:NE-1];
  logic [QW-1:0] q_r    [0:ND-1][0:NE-1];
  logic [NE-1:0] neg_r  [0:ND-1];
  logic [DW-1:0] den_r  [0:ND-1];
  logic [ND-1:0] zero_r;

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [DW:0]   rem_in [0:NE-1];
    logic [DW:0]   diff   [0:NE-1];
    logic [QW-1:0] q_in   [0:NE-1];
    logic [DW-1:0] den_in;
    logic [NE-1:0] neg_in;
    logic          zero_in;

    always_comb begin
      if (k == 0) begin
        den_in  = den3_r;
        neg_in  = neg3_r;
        zero_in = zero3_r;
      end else begin
        den_in  = den_r[(k == 0) ? 0 : k-1];
        neg_in  = neg_r[(k == 0) ? 0 : k-1];
        zero_in = zero_r[(k == 0) ? 0 : k-1];
      end
      for (int e = 0; e < NE; e++) begin
        if (k == 0) begin
          rem_in[e] = {1'b0, mag3_r[e]};
          q_in[e]   = '0;
        end else begin
          rem_in[e] = {rem_r[(k == 0) ? 0 : k-1][e], 1'b0};
          q_in[e]   = q_r[(k == 0) ? 0 : k-1][e];
        end
        diff[e] = rem_in[e] - {1'b0, den_in};
      end
    end

    always_ff @(posedge clk) begin
      if (ready[4+k]) begin
        den_r[k]  <= den_in;
        neg_r[k]  <= neg_in;
        zero_r[k] <= zero_in;
        for (int e = 0; e < NE; e++) begin
          if (rem_in[e] >= {1'b0, den_in}) begin
            rem_r[k][e] <= diff[e][DW-1:0];
            q_r[k][e]   <= {q_in[e][QW-2:0], 1'b1};
          end else begin
            rem_r[k][e] <= rem_in[e][DW-1:0];
            q_r[k][e]   <= {q_in[e][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output stage: round half away from zero, clamp to one, restore the sign, pick the frame.
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRACTION_BITS;

  logic [QW:0]          rsum [0:NE-1];
  logic [QW-1:0]        rnd  [0:NE-1];
  logic signed [EW-1:0] r    [0:NE-1];
  logic signed [EW-1:0] m    [0:NE-1];
  logic [NE*EW-1:0]     m_flat;
  logic [NE*EW-1:0]     out_tdata_r;
  logic                 out_tuser_r;

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      rsum[e] = {1'b0, q_r[ND-1][e]} + (QW+1)'(1);
      rnd[e]  = rsum[e][QW:1];
      if (rnd[e] > ONE_Q) begin
        rnd[e] = ONE_Q;
      end
      r[e] = neg_r[ND-1][e] ? -EW'(rnd[e]) : EW'(rnd[e]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (frame_r == qrm_pkg::FRAME_GRID_TO_CAMERA) begin
          m[i*3+j] = -r[j*3 + ((i == 0) ? 1 : (i == 1) ? 0 : 2)];
        end else begin
          m[i*3+j] = r[i*3+j];
        end
        if (zero_r[ND-1]) begin
          m[i*3+j] = '0;
        end
      end
    end
    for (int e = 0; e < NE; e++) begin
      m_flat[e*EW +: EW] = m[e];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[OUT_STAGE]) begin
      out_tdata_r <= m_flat;
      out_tuser_r <= !zero_r[ND-1];
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  // A zero quaternion must leave an all-zero matrix.
  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("zero quaternion produced a nonzero matrix");

  // Entry m00 never leaves the range of plus or minus one.
  a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[EW-1:0]) <= $signed(EW'(ONE_Q)) &&
                    $signed(out_tdata[EW-1:0]) >= -$signed(EW'(ONE_Q))))
    else $error("matrix entry m00 outside the unit range");

  // The input side only stalls when every stage holds a beat and the output is held.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input stalled while the pipeline had room");

endmodule

@@ sim/tb_quaternion_to_rotation_matrix.sv @@
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix;

  localparam int FRAC = qrm_pkg::FRACTION_BITS_DEF;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM = 1200;
  localparam longint CYCLE_LIMIT = 200000;

  // Plus and minus one in Q1.30.
  localparam logic [31:0] ONE = 32'h4000_0000;
  localparam logic [31:0] MONE = 32'hC000_0000;

  typedef struct packed {
    logic                 ok;
    logic [9*32-1:0]      m;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [qrm_pkg::NUM_ENTRIES*qrm_pkg::ENTRY_WIDTH-1:0] out_tdata;
  logic out_tuser;

  quaternion_to_rotation_matrix DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame setting as the block should currently hold it.
  logic frame_sel = qrm_pkg::FRAME_DRONE_TO_WORLD;
  matrix_t pending_matrices[$];
  int errors = 0;
  longint cycles = 0;

  // Rounded, saturated num * 2^FRAC / den, ties away from zero; den > 0.
  function automatic logic signed [31:0] ratio_q(logic signed [127:0] num,
                                                 logic signed [127:0] den);
    logic neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << (FRAC + 1)) / den + 1) >> 1;
    if (q > (128'd1 << FRAC)) q = 128'd1 << FRAC;
    return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // Rotation matrix of one quaternion in the selected frame.
  function automatic matrix_t rotation_of(logic [127:0] d, logic frame);
    logic signed [127:0] x, y, z, w, den;
    logic signed [127:0] num[3][3];
    logic signed [31:0] r[3][3];
    logic signed [31:0] v;
    matrix_t res;
    int col;
    x = $signed(d[31:0]);
    y = $signed(d[63:32]);
    z = $signed(d[95:64]);
    w = $signed(d[127:96]);
    den = x*x + y*y + z*z + w*w;
    res = '0;
    if (den == 0) return res;
    num[0][0] = den - 2*(y*y + z*z);
    num[0][1] = 2*(x*y - w*z);
    num[0][2] = 2*(x*z + w*y);
    num[1][0] = 2*(x*y + w*z);
    num[1][1] = den - 2*(x*x + z*z);
    num[1][2] = 2*(y*z - w*x);
    num[2][0] = 2*(x*z - w*y);
    num[2][1] = 2*(y*z + w*x);
    num[2][2] = den - 2*(x*x + y*y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i][j] = ratio_q(num[i][j], den);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        col = (i == 0) ? 1 : (i == 1) ? 0 : 2;
        v = (frame == qrm_pkg::FRAME_GRID_TO_CAMERA) ? -r[j][col] : r[i][j];
        res.m[(i*3+j)*32 +: 32] = v;
      end
    end
    res.ok = 1'b1;
    return res;
  endfunction

  function automatic logic [127:0] pack_quat(int x, int y, int z, int w);
    return {w, z, y, x};
  endfunction

  // Random component: half full range, the rest small or extreme magnitudes.
  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 6) - 3;
      1: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Directed beats and, where obvious, the matrix they must give (frame 0).
  logic [127:0] dir_quat[N_DIRECTED];
  matrix_t dir_expect[N_DIRECTED];
  bit dir_has_expect[N_DIRECTED];

  initial begin
    for (int k = 0; k < N_DIRECTED; k++) dir_has_expect[k] = 1'b0;
    // Zero quaternion: no normalisation possible.
    dir_quat[0] = '0;
    dir_expect[0] = '0; dir_has_expect[0] = 1'b1;
    // Identity from a positive, a negative and an extreme w.
    dir_quat[1] = pack_quat(0, 0, 0, 1);
    dir_quat[2] = pack_quat(0, 0, 0, -1);
    dir_quat[3] = pack_quat(0, 0, 0, 32'sh8000_0000);
    for (int k = 1; k <= 3; k++) begin
      dir_expect[k] = '0; dir_expect[k].ok = 1'b1;
      dir_expect[k].m[0 +: 32] = ONE;
      dir_expect[k].m[4*32 +: 32] = ONE;
      dir_expect[k].m[8*32 +: 32] = ONE;
      dir_has_expect[k] = 1'b1;
    end
    // Half turn about x: diag(1, -1, -1).
    dir_quat[4] = pack_quat(32'sh7FFF_FFFF, 0, 0, 0);
    dir_expect[4] = '0; dir_expect[4].ok = 1'b1;
    dir_expect[4].m[0 +: 32] = ONE;
    dir_expect[4].m[4*32 +: 32] = MONE;
    dir_expect[4].m[8*32 +: 32] = MONE;
    dir_has_expect[4] = 1'b1;
    dir_quat[5] = pack_quat(0, 32'sh8000_0000, 0, 0);
    dir_quat[6] = pack_quat(0, 0, 5, 0);
    dir_quat[7] = pack_quat(1, 1, 1, 1);
    dir_quat[8] = pack_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    dir_quat[9] = pack_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    dir_quat[10] = pack_quat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    dir_quat[11] = pack_quat(1, 0, 0, 1);
    dir_quat[12] = pack_quat(0, 1, 0, 1);
    dir_quat[13] = pack_quat(0, 0, 1, -1);
    // Ratios that land on a rounding tie or need the saturation.
    dir_quat[14] = pack_quat(1, 2, 3, 4);
    dir_quat[15] = pack_quat(3, 0, 0, 1);
    dir_quat[16] = pack_quat(-1, -1, -1, 32'sh7FFF_FFFF);
    dir_quat[17] = pack_quat(32'sh7FFF_FFFF, 1, 0, 0);
    dir_quat[18] = pack_quat(-1, -1, -1, -1);
    dir_quat[19] = pack_quat(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0);
    dir_quat[20] = pack_quat(7, -3, 11, -13);
    dir_quat[21] = pack_quat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  end

  // Drive one beat and queue its expected matrix on acceptance.
  task automatic send_quat(logic [127:0] q, bit has_fixed, matrix_t fixed);
    matrix_t exp_m;
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk);
    in_tdata = q;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    exp_m = has_fixed ? fixed : rotation_of(q, frame_sel);
    pending_matrices.push_back(exp_m);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait for the pipeline to drain, then set the frame register.
  task automatic set_frame(logic f);
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (FRAC + 12) @(negedge clk);
    cfg_wr_data = f;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    frame_sel = f;
  endtask

  // Receiver: random back-pressure, with stretches of none.
  initial begin
    int stall;
    bit busy_phase;
    busy_phase = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) busy_phase = !busy_phase;
      stall = busy_phase ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Check each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    matrix_t exp_m;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected result beat %h/%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_m = pending_matrices.pop_front();
        if (out_tuser !== exp_m.ok) begin
          $display("%0t: valid_res expected %b actual %b", $time, exp_m.ok, out_tuser);
          errors++;
        end
        for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
          if (out_tdata[k*32 +: 32] !== exp_m.m[k*32 +: 32]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     exp_m.m[k*32 +: 32], out_tdata[k*32 +: 32]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quaternion_to_rotation_matrix NOT OK");
      $finish;
    end
  end

  // Stimulus: directed rows in both frames, then random phases.
  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int k = 0; k < N_DIRECTED; k++)
      send_quat(dir_quat[k], dir_has_expect[k], dir_expect[k]);
    set_frame(qrm_pkg::FRAME_GRID_TO_CAMERA);
    for (int k = 0; k < N_DIRECTED; k++)
      send_quat(dir_quat[k], 1'b0, '0);
    for (int phase = 0; phase < 6; phase++) begin
      set_frame((phase % 2 == 0) ? qrm_pkg::FRAME_DRONE_TO_WORLD
                                 : qrm_pkg::FRAME_GRID_TO_CAMERA);
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        if ($urandom_range(0, 99) == 0) send_quat('0, 1'b0, '0);
        else send_quat({rand_component(), rand_component(), rand_component(),
                        rand_component()}, 1'b0, '0);
      end
    end
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (FRAC + 20) @(negedge clk);
    if (errors == 0) begin
      $display("tb_quaternion_to_rotation_matrix OK");
    end else begin
      $display("tb_quaternion_to_rotation_matrix NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qrm_pkg.sv
rtl/quaternion_to_rotation_matrix.sv
sim/tb_quaternion_to_rotation_matrix.sv
